// ----- design/grm_pkg.sv -----
package grm_pkg;

   localparam int MAX_MASSES_DEF = 16;
   localparam int MAX_STEPS_DEF  = 600;
   localparam int FRAC_BITS_DEF  = 20;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MASS_COUNT  = 3'd0,
      CSR_GRAV_CONST  = 3'd1,
      CSR_HALF_EXTENT = 3'd2,
      CSR_STEP_LENGTH = 3'd3,
      CSR_ACCEL_BOOST = 3'd4,
      CSR_SOFTEN_SQ   = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_START = 2'd1,
      ACT_STEP  = 2'd2
   } action_type;

   localparam logic [4:0]  MASS_COUNT_RST  = 5'd0;
   localparam logic [30:0] GRAV_CONST_RST  = 31'd1048576;
   localparam logic [30:0] HALF_EXTENT_RST = 31'd10485760;
   localparam logic [30:0] STEP_LENGTH_RST = 31'd52429;
   localparam logic [30:0] ACCEL_BOOST_RST = 31'd2621440;
   localparam logic [30:0] SOFTEN_SQ_RST   = 31'd2621;

   localparam logic [30:0] Q_MAX = 31'h7fffffff;

   typedef struct packed {
      logic [1:0]         action;
      logic [3:0]         slot;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] heading_x;
      logic signed [31:0] heading_y;
      logic signed [31:0] heading_z;
      logic [30:0]        mass_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] vert_x;
      logic signed [31:0] vert_y;
      logic signed [31:0] vert_z;
      logic               ended;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic [30:0]        amount;
   } mass_type;

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      mag32 = v[31] ? 32'd0 - 32'(v) : 32'(v);
   endfunction

   function automatic logic signed [65:0] sx66(input logic signed [31:0] v);
      sx66 = 66'(v);
   endfunction

   function automatic logic signed [65:0] smag(input logic neg, input logic [63:0] m);
      logic signed [65:0] p;
      p = $signed({2'b00, m});
      smag = neg ? -p : p;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sh0_7fffffff) begin
         sat32 = 32'sh7fffffff;
      end else if (v < -66'sh0_80000000) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

   function automatic logic [30:0] cap31(input logic [63:0] v);
      cap31 = (v > 64'(Q_MAX)) ? Q_MAX : v[30:0];
   endfunction

endpackage

// ----- design/gravity_ray_march_step.sv -----
// gravity ray marcher: traces one ray through the softened field of a mass table
// req channel: one transfer per item; action load writes a mass table entry,
// start sets the ray origin and direction, step advances the ray by one step
// rsp channel: one vertex per start, and per step while the ray is live;
// ended marks the last vertex of the ray
// csr port: user must write registers only while the block is idle; not enforced
// a start: sum of squares, and unless the heading is zero, a shift search,
// a square root and three divides to renormalize the heading
// a step: per active mass one table read, a square root and five divides through
// the shared divider, then the direction update, the renormalization as for a
// start and the position advance along the new direction
// the mass table sits in a ram with registered read, one entry read per mass
// req_stall is high whenever an item is in progress
// the result register lets the next item be taken while rsp is stalled;
// a finished vertex waits only if the previous one still has not transferred
// reset: no live ray, registers at defaults, mass table contents undefined
module gravity_ray_march_step import grm_pkg::*; #(
   parameter int MAX_MASSES = MAX_MASSES_DEF,
   parameter int MAX_STEPS  = MAX_STEPS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = (MAX_MASSES > 1) ? $clog2(MAX_MASSES) : 1;
   localparam int CW = $clog2(MAX_MASSES + 1);
   localparam int DW = 64 + FRAC_BITS;
   localparam int ACW = 42;
   localparam logic ONE_STEP = (MAX_STEPS <= 1);

   typedef enum logic [22:0] {
      ST_IDLE = 23'h000001,
      ST_RD   = 23'h000002,
      ST_DIFF = 23'h000004,
      ST_R2   = 23'h000008,
      ST_GM   = 23'h000010,
      ST_K    = 23'h000020,
      ST_T    = 23'h000040,
      ST_Q    = 23'h000080,
      ST_U    = 23'h000100,
      ST_UM   = 23'h000200,
      ST_UA   = 23'h000400,
      ST_NEXT = 23'h000800,
      ST_DM   = 23'h001000,
      ST_DA   = 23'h002000,
      ST_NSUM = 23'h004000,
      ST_NSH  = 23'h008000,
      ST_NDIV = 23'h010000,
      ST_NSET = 23'h020000,
      ST_PM   = 23'h040000,
      ST_PA   = 23'h080000,
      ST_FIN  = 23'h100000,
      ST_SQRT = 23'h200000,
      ST_DIV  = 23'h400000
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;

   logic [1:0]    idx_ff, idx_in;
   logic [CW-1:0] e_ff, e_in;
   logic          start_ff, start_in;
   logic          end_ff, end_in;
   logic          done_ff, done_in;
   logic [9:0]    steps_ff, steps_in;

   logic [4:0]  mass_count_ff, mass_count_in;
   logic [30:0] grav_ff, grav_in, half_ff, half_in, step_ff, step_in;
   logic [30:0] boost_ff, boost_in, soft_ff, soft_in;

   logic signed [31:0]    pos_ff [3], pos_in [3];
   logic signed [31:0]    dir_ff [3], dir_in [3];
   logic signed [31:0]    d_ff [3], d_in [3];
   logic signed [31:0]    v_ff [3], v_in [3];
   logic signed [ACW-1:0] acc_ff [3], acc_in [3];

   logic [30:0] amt_ff, amt_in;
   logic [30:0] q_ff, q_in;
   logic [63:0] r2_ff, r2_in;
   logic [4:0]  sh_ff, sh_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] mul_a, mul_b;

   logic [63:0] sq_n_ff, sq_n_in, sq_res_ff, sq_res_in, sq_bit_ff, sq_bit_in;
   logic [DW-1:0] rem_ff, rem_in, dsh_ff, dsh_in;
   logic [30:0]   quot_ff, quot_in;
   logic [5:0]    div_cnt_ff, div_cnt_in;

   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   mass_type      ram_wdata, ram_rdata;

   logic          req_xfer;
   logic [CW-1:0] n_act;
   logic [1:0]    ix;

   grm_ram #(
      .WIDTH ($bits(mass_type)),
      .DEPTH (MAX_MASSES)
   ) u_mass_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (e_ff[AW-1:0]),
      .rd_data (ram_rdata)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign ix        = (idx_ff == 2'd3) ? 2'd0 : idx_ff;
   assign n_act     = (32'(mass_count_ff) > MAX_MASSES) ? CW'(MAX_MASSES) : CW'(mass_count_ff);

   assign ram_we    = req_xfer && (req_data.action == ACT_LOAD) && (32'(req_data.slot) < MAX_MASSES);
   assign ram_waddr = AW'(req_data.slot);
   assign ram_wdata = '{px: req_data.pos_x, py: req_data.pos_y, pz: req_data.pos_z,
                        amount: req_data.mass_value};

   assign prod_in = 64'(mul_a) * 64'(mul_b);

   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      case (state_ff)
         ST_R2, ST_NSUM: begin
            mul_a = (state_ff == ST_R2) ? mag32(d_ff[ix]) : mag32(v_ff[ix]);
            mul_b = mul_a;
         end
         ST_GM: begin
            mul_a = 32'(grav_ff);
            mul_b = 32'(amt_ff);
         end
         ST_K: begin
            mul_a = 32'(cap31(prod_ff >> FRAC_BITS));
            mul_b = 32'(boost_ff);
         end
         ST_UM: begin
            mul_a = 32'(quot_ff);
            mul_b = 32'(q_ff);
         end
         ST_DM: begin
            mul_a = mag32(sat32(66'(acc_ff[ix])));
            mul_b = 32'(step_ff);
         end
         ST_PM: begin
            mul_a = mag32(dir_ff[ix]);
            mul_b = 32'(step_ff);
         end
         default: begin
            mul_a = 32'd0;
         end
      endcase
   end

   always_comb begin
      logic [63:0]        sum;
      logic signed [31:0] np;
      logic               ge;
      logic [9:0]         sn;
      logic               fin;

      state_in      = state_ff;
      ret_in        = ret_ff;
      idx_in        = idx_ff;
      e_in          = e_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      done_in       = done_ff;
      steps_in      = steps_ff;
      mass_count_in = mass_count_ff;
      grav_in       = grav_ff;
      half_in       = half_ff;
      step_in       = step_ff;
      boost_in      = boost_ff;
      soft_in       = soft_ff;
      pos_in        = pos_ff;
      dir_in        = dir_ff;
      d_in          = d_ff;
      v_in          = v_ff;
      acc_in        = acc_ff;
      amt_in        = amt_ff;
      q_in          = q_ff;
      r2_in         = r2_ff;
      sh_in         = sh_ff;
      sq_n_in       = sq_n_ff;
      sq_res_in     = sq_res_ff;
      sq_bit_in     = sq_bit_ff;
      rem_in        = rem_ff;
      dsh_in        = dsh_ff;
      quot_in       = quot_ff;
      div_cnt_in    = div_cnt_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      sum = r2_ff + prod_ff;
      np  = sat32(sx66(pos_ff[ix]) + smag(dir_ff[ix][31], prod_ff >> FRAC_BITS));
      ge  = (rem_ff >= dsh_ff);
      sn  = steps_ff + 10'd1;
      fin = 1'b0;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_MASS_COUNT:  mass_count_in = csr_wdata[4:0];
            CSR_GRAV_CONST:  grav_in = csr_wdata;
            CSR_HALF_EXTENT: half_in = csr_wdata;
            CSR_STEP_LENGTH: step_in = csr_wdata;
            CSR_ACCEL_BOOST: boost_in = csr_wdata;
            CSR_SOFTEN_SQ:   soft_in = csr_wdata;
            default: begin
               grav_in = grav_ff;
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_data.action)
                  ACT_START: begin
                     pos_in[0] = req_data.pos_x;
                     pos_in[1] = req_data.pos_y;
                     pos_in[2] = req_data.pos_z;
                     v_in[0]   = req_data.heading_x;
                     v_in[1]   = req_data.heading_y;
                     v_in[2]   = req_data.heading_z;
                     steps_in  = 10'd0;
                     start_in  = 1'b1;
                     idx_in    = 2'd0;
                     r2_in     = 64'd0;
                     state_in  = ST_NSUM;
                  end
                  ACT_STEP: begin
                     if (!done_ff) begin
                        start_in = 1'b0;
                        end_in   = 1'b0;
                        idx_in   = 2'd0;
                        e_in     = '0;
                        for (int i = 0; i < 3; i++) acc_in[i] = '0;
                        state_in = (n_act == '0) ? ST_DM : ST_RD;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_RD: begin
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            d_in[0]  = sat32(sx66(pos_ff[0]) - sx66(ram_rdata.px));
            d_in[1]  = sat32(sx66(pos_ff[1]) - sx66(ram_rdata.py));
            d_in[2]  = sat32(sx66(pos_ff[2]) - sx66(ram_rdata.pz));
            amt_in   = ram_rdata.amount;
            r2_in    = 64'(soft_ff) << FRAC_BITS;
            idx_in   = 2'd0;
            state_in = ST_R2;
         end
         ST_R2: begin
            if (idx_ff != 2'd0) r2_in = sum;
            idx_in = idx_ff + 2'd1;
            if (idx_ff == 2'd3) begin
               if (sum == 64'd0) begin
                  state_in = ST_NEXT;
               end else begin
                  sq_n_in   = sum;
                  sq_res_in = 64'd0;
                  sq_bit_in = 64'd1 << 62;
                  ret_in    = ST_GM;
                  state_in  = ST_SQRT;
               end
            end
         end
         ST_GM: begin
            state_in = ST_K;
         end
         ST_K: begin
            state_in = ST_T;
         end
         ST_T: begin
            rem_in     = DW'(cap31(prod_ff >> FRAC_BITS)) << FRAC_BITS;
            dsh_in     = DW'(sq_res_ff[31:0]) << 31;
            quot_in    = '0;
            div_cnt_in = 6'd32;
            ret_in     = ST_Q;
            state_in   = ST_DIV;
         end
         ST_Q: begin
            rem_in     = DW'(quot_ff) << FRAC_BITS;
            dsh_in     = DW'(sq_res_ff[31:0]) << 31;
            quot_in    = '0;
            div_cnt_in = 6'd32;
            idx_in     = 2'd0;
            ret_in     = ST_U;
            state_in   = ST_DIV;
         end
         ST_U: begin
            if (idx_ff == 2'd0) q_in = quot_ff;
            rem_in     = DW'(mag32(d_ff[ix])) << FRAC_BITS;
            dsh_in     = DW'(sq_res_ff[31:0]) << 31;
            quot_in    = '0;
            div_cnt_in = 6'd32;
            ret_in     = ST_UM;
            state_in   = ST_DIV;
         end
         ST_UM: begin
            state_in = ST_UA;
         end
         ST_UA: begin
            acc_in[ix] = ACW'(66'(acc_ff[ix]) - smag(d_ff[ix][31], prod_ff >> FRAC_BITS));
            if (idx_ff == 2'd2) begin
               state_in = ST_NEXT;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = ST_U;
            end
         end
         ST_NEXT: begin
            e_in   = e_ff + 1'b1;
            idx_in = 2'd0;
            if ((CW+1)'(e_ff) + 1'b1 < (CW+1)'(n_act)) begin
               state_in = ST_RD;
            end else begin
               state_in = ST_DM;
            end
         end
         ST_DM: begin
            state_in = ST_DA;
         end
         ST_DA: begin
            v_in[ix] = sat32(sx66(dir_ff[ix]) + smag(acc_ff[ix][ACW-1], prod_ff >> FRAC_BITS));
            if (idx_ff == 2'd2) begin
               idx_in   = 2'd0;
               r2_in    = 64'd0;
               state_in = ST_NSUM;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = ST_DM;
            end
         end
         ST_NSUM: begin
            if (idx_ff != 2'd0) r2_in = sum;
            idx_in = idx_ff + 2'd1;
            if (idx_ff == 2'd3) begin
               if (sum == 64'd0) begin
                  for (int i = 0; i < 3; i++) dir_in[i] = '0;
                  done_in  = 1'b1;
                  end_in   = 1'b1;
                  state_in = ST_FIN;
               end else begin
                  sh_in    = 5'd0;
                  state_in = ST_NSH;
               end
            end
         end
         ST_NSH: begin
            if (r2_ff[63:60] == 4'd0) begin
               r2_in = r2_ff << 2;
               sh_in = sh_ff + 5'd1;
            end else begin
               sq_n_in   = r2_ff;
               sq_res_in = 64'd0;
               sq_bit_in = 64'd1 << 62;
               idx_in    = 2'd0;
               ret_in    = ST_NDIV;
               state_in  = ST_SQRT;
            end
         end
         ST_NDIV: begin
            rem_in     = DW'(mag32(v_ff[ix])) << (FRAC_BITS + int'(sh_ff));
            dsh_in     = DW'(sq_res_ff[31:0]) << 31;
            quot_in    = '0;
            div_cnt_in = 6'd32;
            ret_in     = ST_NSET;
            state_in   = ST_DIV;
         end
         ST_NSET: begin
            dir_in[ix] = sat32(smag(v_ff[ix][31], 64'(quot_ff)));
            if (idx_ff == 2'd2) begin
               idx_in = 2'd0;
               if (start_ff) begin
                  done_in  = ONE_STEP;
                  end_in   = ONE_STEP;
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_PM;
               end
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = ST_NDIV;
            end
         end
         ST_PM: begin
            state_in = ST_PA;
         end
         ST_PA: begin
            pos_in[ix] = np;
            fin = end_ff || (mag32(np) > 32'(half_ff));
            end_in = fin;
            if (idx_ff == 2'd2) begin
               steps_in = sn;
               fin      = fin || ((11'(sn) + 11'd1) >= 11'(MAX_STEPS));
               end_in   = fin;
               done_in  = fin;
               state_in = ST_FIN;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = ST_PM;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = '{vert_x: pos_ff[0], vert_y: pos_ff[1], vert_z: pos_ff[2],
                                ended: end_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SQRT: begin
            if (sq_n_ff >= sq_res_ff + sq_bit_ff) begin
               sq_n_in   = sq_n_ff - (sq_res_ff + sq_bit_ff);
               sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_in = sq_res_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            if (sq_bit_ff[0]) state_in = ret_ff;
         end
         ST_DIV: begin
            if (div_cnt_ff == 6'd32) begin
               if (ge) begin
                  quot_in  = Q_MAX;
                  state_in = ret_ff;
               end else begin
                  dsh_in     = dsh_ff >> 1;
                  div_cnt_in = 6'd31;
               end
            end else begin
               if (ge) rem_in = rem_ff - dsh_ff;
               quot_in    = {quot_ff[29:0], ge};
               dsh_in     = dsh_ff >> 1;
               div_cnt_in = div_cnt_ff - 6'd1;
               if (div_cnt_ff == 6'd1) state_in = ret_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ret_ff        <= ST_IDLE;
         idx_ff        <= 2'd0;
         e_ff          <= '0;
         start_ff      <= 1'b0;
         end_ff        <= 1'b0;
         done_ff       <= 1'b1;
         steps_ff      <= 10'd0;
         mass_count_ff <= MASS_COUNT_RST;
         grav_ff       <= GRAV_CONST_RST;
         half_ff       <= HALF_EXTENT_RST;
         step_ff       <= STEP_LENGTH_RST;
         boost_ff      <= ACCEL_BOOST_RST;
         soft_ff       <= SOFTEN_SQ_RST;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
            dir_ff[i] <= '0;
         end
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         idx_ff        <= idx_in;
         e_ff          <= e_in;
         start_ff      <= start_in;
         end_ff        <= end_in;
         done_ff       <= done_in;
         steps_ff      <= steps_in;
         mass_count_ff <= mass_count_in;
         grav_ff       <= grav_in;
         half_ff       <= half_in;
         step_ff       <= step_in;
         boost_ff      <= boost_in;
         soft_ff       <= soft_in;
         pos_ff        <= pos_in;
         dir_ff        <= dir_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff       <= d_in;
      v_ff       <= v_in;
      acc_ff     <= acc_in;
      amt_ff     <= amt_in;
      q_ff       <= q_in;
      r2_ff      <= r2_in;
      sh_ff      <= sh_in;
      prod_ff    <= prod_in;
      sq_n_ff    <= sq_n_in;
      sq_res_ff  <= sq_res_in;
      sq_bit_ff  <= sq_bit_in;
      rem_ff     <= rem_in;
      dsh_ff     <= dsh_in;
      quot_ff    <= quot_in;
      div_cnt_ff <= div_cnt_in;
      rsp_ff     <= rsp_in;
   end

endmodule

// ----- design/grm_ram.sv -----
module grm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- tb/tb_gravity_ray_march_step.sv -----
module tb_gravity_ray_march_step;
   import grm_pkg::*;

   localparam int FB         = FRAC_BITS_DEF;
   localparam int STEP_LIMIT = MAX_STEPS_DEF;
   localparam int NUM_SLOTS  = MAX_MASSES_DEF;
   localparam longint CYCLE_LIMIT = 40000000;
   localparam int SETTLE     = 5000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   gravity_ray_march_step uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   req_type req_pend[$];
   rsp_type vertex_q[$];
   int      mismatches;
   longint  cycles;
   int      random_items;

   // predictor state
   longint          mx[NUM_SLOTS];
   longint          my[NUM_SLOTS];
   longint          mz[NUM_SLOTS];
   longint unsigned mamt[NUM_SLOTS];
   longint          ray_x, ray_y, ray_z;
   longint          dir_x, dir_y, dir_z;
   int unsigned     steps_done;
   bit              ray_over;
   longint unsigned n_active, g_const, half_ext, step_len, boost, soft_sq;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void queue_item(req_type r);
      req_pend.insert(req_pend.size(), r);
   endfunction

   function automatic void expect_vertex(rsp_type v);
      vertex_q.insert(vertex_q.size(), v);
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned absv(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint signed_of(bit neg, longint unsigned m);
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint qmul(longint a, longint b);
      return signed_of((a < 0) != (b < 0), (absv(a) * absv(b)) >> FB);
   endfunction

   function automatic longint unsigned sqrt_floor(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint unsigned cap31(longint unsigned v);
      return v > 64'd2147483647 ? 64'd2147483647 : v;
   endfunction

   // sets the direction to the unit vector of (x,y,z), 0 when the vector is zero
   function automatic bit set_unit_dir(longint x, longint y, longint z);
      longint unsigned sum, len;
      int s;
      sum = absv(x) * absv(x) + absv(y) * absv(y) + absv(z) * absv(z);
      s = 0;
      if (sum == 0) begin
         dir_x = 0; dir_y = 0; dir_z = 0;
         return 1'b0;
      end
      while ((sum >> 60) == 0) begin
         sum = sum << 2;
         s++;
      end
      len = sqrt_floor(sum);
      dir_x = signed_of(x < 0, (absv(x) << (FB + s)) / len);
      dir_y = signed_of(y < 0, (absv(y) << (FB + s)) / len);
      dir_z = signed_of(z < 0, (absv(z) << (FB + s)) / len);
      return 1'b1;
   endfunction

   function automatic rsp_type vertex_of(bit last);
      rsp_type v;
      v.vert_x = ray_x[31:0];
      v.vert_y = ray_y[31:0];
      v.vert_z = ray_z[31:0];
      v.ended  = last;
      return v;
   endfunction

   task automatic predict_vertex(req_type r);
      longint ax, ay, az, ddx, ddy, ddz, nx, ny, nz;
      longint unsigned n, r2, rr, gm, k, t, q;
      bit last;
      case (r.action)
         ACT_LOAD: begin
            mx[r.slot] = longint'(r.pos_x);
            my[r.slot] = longint'(r.pos_y);
            mz[r.slot] = longint'(r.pos_z);
            mamt[r.slot] = 64'(r.mass_value);
         end
         ACT_START: begin
            ray_x = longint'(r.pos_x); ray_y = longint'(r.pos_y); ray_z = longint'(r.pos_z);
            steps_done = 0;
            ray_over = !set_unit_dir(longint'(r.heading_x), longint'(r.heading_y),
                                     longint'(r.heading_z)) || STEP_LIMIT <= 1;
            expect_vertex(vertex_of(ray_over));
         end
         ACT_STEP: begin
            if (!ray_over) begin
               n = n_active > 64'(NUM_SLOTS) ? 64'(NUM_SLOTS) : n_active;
               ax = 0; ay = 0; az = 0;
               for (int e = 0; e < n; e++) begin
                  ddx = clamp32(ray_x - mx[e]);
                  ddy = clamp32(ray_y - my[e]);
                  ddz = clamp32(ray_z - mz[e]);
                  r2 = (soft_sq << FB) + absv(ddx) * absv(ddx) + absv(ddy) * absv(ddy)
                       + absv(ddz) * absv(ddz);
                  if (r2 != 0) begin
                     rr = sqrt_floor(r2);
                     gm = cap31((g_const * mamt[e]) >> FB);
                     k  = cap31((gm * boost) >> FB);
                     t  = cap31((k << FB) / rr);
                     q  = cap31((t << FB) / rr);
                     ax -= qmul(signed_of(ddx < 0, (absv(ddx) << FB) / rr), longint'(q));
                     ay -= qmul(signed_of(ddy < 0, (absv(ddy) << FB) / rr), longint'(q));
                     az -= qmul(signed_of(ddz < 0, (absv(ddz) << FB) / rr), longint'(q));
                  end
               end
               ax = clamp32(ax); ay = clamp32(ay); az = clamp32(az);
               nx = clamp32(dir_x + qmul(ax, longint'(step_len)));
               ny = clamp32(dir_y + qmul(ay, longint'(step_len)));
               nz = clamp32(dir_z + qmul(az, longint'(step_len)));
               if (!set_unit_dir(nx, ny, nz)) begin
                  ray_over = 1'b1;
                  expect_vertex(vertex_of(1'b1));
               end else begin
                  ray_x = clamp32(ray_x + qmul(dir_x, longint'(step_len)));
                  ray_y = clamp32(ray_y + qmul(dir_y, longint'(step_len)));
                  ray_z = clamp32(ray_z + qmul(dir_z, longint'(step_len)));
                  last = absv(ray_x) > half_ext || absv(ray_y) > half_ext
                         || absv(ray_z) > half_ext;
                  steps_done = (steps_done + 1) & 10'h3ff;
                  if (steps_done + 1 >= STEP_LIMIT) last = 1'b1;
                  ray_over = last;
                  expect_vertex(vertex_of(last));
               end
            end
         end
         default: ;
      endcase
   endtask

   // driver: bursts and gaps
   int burst_left, gap_left;
   always @(posedge clock) begin
      req_type nxt;
      logic    v_nxt;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         v_nxt = req_valid;
         if (req_valid && !req_stall) begin
            predict_vertex(req_data);
            v_nxt = 1'b0;
         end
         if (!v_nxt) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
            end else if (req_pend.size() > 0) begin
               nxt = req_pend.pop_front();
               req_data <= nxt;
               v_nxt = 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= int'($urandom_range(1, 20));
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 15));
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
         req_valid <= v_nxt;
      end
   end

   // receiver stall pattern and vertex check
   int stall_mode, stall_left;
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode <= 0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (vertex_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected vertex %h %h %h ended %b", rsp_data.vert_x,
                           rsp_data.vert_y, rsp_data.vert_z, rsp_data.ended);
            end else begin
               want = vertex_q.pop_front();
               if (want.vert_x !== rsp_data.vert_x || want.vert_y !== rsp_data.vert_y
                   || want.vert_z !== rsp_data.vert_z || want.ended !== rsp_data.ended) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("vertex mismatch: expected %h %h %h ended %b, got %h %h %h ended %b",
                              want.vert_x, want.vert_y, want.vert_z, want.ended,
                              rsp_data.vert_x, rsp_data.vert_y, rsp_data.vert_z,
                              rsp_data.ended);
               end
            end
         end
         if (stall_left == 0) begin
            stall_mode <= int'($urandom_range(0, 2));
            stall_left <= int'($urandom_range(20, 300));
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 1) == 1);
            default: rsp_stall <= ($urandom_range(0, 9) < 8);
         endcase
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_gravity_ray_march_step: FAIL");
         $finish;
      end
   end

   function automatic req_type make_item(action_type a);
      req_type r;
      r.action     = a;
      r.slot       = 4'($urandom_range(0, 15));
      r.pos_x      = $urandom;
      r.pos_y      = $urandom;
      r.pos_z      = $urandom;
      r.heading_x  = $urandom;
      r.heading_y  = $urandom;
      r.heading_z  = $urandom;
      r.mass_value = 31'($urandom);
      return r;
   endfunction

   function automatic logic signed [31:0] near(longint unsigned span);
      longint v;
      v = longint'($urandom_range(0, 32'(span > 64'd2147483647 ? 64'd2147483647 : span)));
      return 32'(($urandom_range(0, 1) == 1) ? -v : v);
   endfunction

   task automatic write_reg(csr_index_type idx, logic [30:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_MASS_COUNT:  n_active = 64'(val[4:0]);
         CSR_GRAV_CONST:  g_const  = 64'(val);
         CSR_HALF_EXTENT: half_ext = 64'(val);
         CSR_STEP_LENGTH: step_len = 64'(val);
         CSR_ACCEL_BOOST: boost    = 64'(val);
         CSR_SOFTEN_SQ:   soft_sq  = 64'(val);
         default: ;
      endcase
   endtask

   task automatic drain();
      while (req_pend.size() > 0 || req_valid || vertex_q.size() > 0) @(posedge clock);
   endtask

   task automatic settle();
      drain();
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_all(logic [30:0] cnt, logic [30:0] g, logic [30:0] h,
                          logic [30:0] st, logic [30:0] b, logic [30:0] sf);
      settle();
      write_reg(CSR_MASS_COUNT, cnt);
      write_reg(CSR_GRAV_CONST, g);
      write_reg(CSR_HALF_EXTENT, h);
      write_reg(CSR_STEP_LENGTH, st);
      write_reg(CSR_ACCEL_BOOST, b);
      write_reg(CSR_SOFTEN_SQ, sf);
   endtask

   // a ray that starts inside the cube with random content, then steps mixed with loads and unknown actions
   task automatic add_ray(int nsteps, int slots);
      req_type r;
      r = make_item(ACT_START);
      r.pos_x = near(half_ext / 2);
      r.pos_y = near(half_ext / 2);
      r.pos_z = near(half_ext / 2);
      if ($urandom_range(0, 3) != 0) begin
         r.heading_x = near(1 << 21);
         r.heading_y = near(1 << 21);
         r.heading_z = near(1 << 21);
      end
      queue_item(r);
      random_items++;
      for (int i = 0; i < nsteps; i++) begin
         case ($urandom_range(0, 19))
            0, 1: begin
               r = make_item(ACT_LOAD);
               r.slot = 4'($urandom_range(0, slots - 1));
               if ($urandom_range(0, 1) == 1) begin
                  r.pos_x = near(half_ext);
                  r.pos_y = near(half_ext);
                  r.pos_z = near(half_ext);
                  r.mass_value = 31'($urandom_range(0, 1 << 22));
               end
               random_items++;
            end
            2: r = make_item(action_type'(2'd3));
            default: begin
               r = make_item(ACT_STEP);
               random_items++;
            end
         endcase
         queue_item(r);
      end
   endtask

   task automatic random_phase(int quota, int max_masses, int max_steps);
      int stop;
      stop = random_items + quota;
      while (random_items < stop) add_ray(int'($urandom_range(1, max_steps)), max_masses);
   endtask

   initial begin
      req_type r;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      mismatches = 0;
      cycles = 0;
      random_items = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         mx[i] = 0; my[i] = 0; mz[i] = 0; mamt[i] = 0;
      end
      ray_x = 0; ray_y = 0; ray_z = 0;
      dir_x = 0; dir_y = 0; dir_z = 0;
      steps_done = 0;
      ray_over = 1'b1;
      n_active = 64'(MASS_COUNT_RST);
      g_const  = 64'(GRAV_CONST_RST);
      half_ext = 64'(HALF_EXTENT_RST);
      step_len = 64'(STEP_LENGTH_RST);
      boost    = 64'(ACCEL_BOOST_RST);
      soft_sq  = 64'(SOFTEN_SQ_RST);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // step with no ray, unknown action, then every slot loaded
      queue_item(make_item(ACT_STEP));
      queue_item(make_item(action_type'(2'd3)));
      for (int s = 0; s < NUM_SLOTS; s++) begin
         r = make_item(ACT_LOAD);
         r.slot = 4'(s);
         if (s == 0) begin
            r.pos_x = 32'sh7fffffff; r.pos_y = 32'sh80000000; r.pos_z = 0;
            r.mass_value = 31'h7fffffff;
         end else if (s == 1) begin
            r.pos_x = 32'sh80000000; r.pos_y = 32'sh7fffffff; r.pos_z = -1;
            r.mass_value = 0;
         end else begin
            r.pos_x = near(half_ext); r.pos_y = near(half_ext); r.pos_z = near(half_ext);
            r.mass_value = 31'($urandom_range(0, 1 << 21));
         end
         queue_item(r);
      end
      // zero heading, extreme start, then a ray from the origin
      r = make_item(ACT_START);
      r.heading_x = 0; r.heading_y = 0; r.heading_z = 0;
      queue_item(r);
      queue_item(make_item(ACT_STEP));
      r = make_item(ACT_START);
      r.pos_x = 32'sh80000000; r.pos_y = 32'sh7fffffff; r.pos_z = 0;
      r.heading_x = 32'sh80000000; r.heading_y = 32'sh7fffffff; r.heading_z = 1;
      queue_item(r);
      queue_item(make_item(ACT_STEP));
      r = make_item(ACT_START);
      r.pos_x = 0; r.pos_y = 0; r.pos_z = 0;
      r.heading_x = 1; r.heading_y = 0; r.heading_z = 0;
      queue_item(r);
      queue_item(make_item(ACT_STEP));
      queue_item(make_item(ACT_STEP));

      // mass coincident with the ray under zero softening, count beyond the table
      set_all(31'd31, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'd0);
      r = make_item(ACT_LOAD);
      r.slot = 4'd5; r.pos_x = 0; r.pos_y = 0; r.pos_z = 0;
      queue_item(r);
      r = make_item(ACT_START);
      r.pos_x = 0; r.pos_y = 0; r.pos_z = 0;
      queue_item(r);
      repeat (3) queue_item(make_item(ACT_STEP));
      random_phase(30, 16, 4);

      // all zero but a mass count of two: no step length, cube of size zero
      set_all(31'd2, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0);
      random_phase(40, 2, 4);

      // straight line up to the step limit
      set_all(31'd0, GRAV_CONST_RST, 31'h7fffffff, STEP_LENGTH_RST, ACCEL_BOOST_RST,
              SOFTEN_SQ_RST);
      r = make_item(ACT_START);
      r.pos_x = 0; r.pos_y = 0; r.pos_z = 0;
      queue_item(r);
      repeat (STEP_LIMIT + 2) queue_item(make_item(ACT_STEP));

      // defaults with a few masses, pausing halfway until the pipe is empty
      set_all(31'd2, GRAV_CONST_RST, HALF_EXTENT_RST, STEP_LENGTH_RST, ACCEL_BOOST_RST,
              SOFTEN_SQ_RST);
      random_phase(60, 2, 30);
      drain();
      random_phase(60, 2, 30);

      for (int p = 0; p < 5; p++) begin
         set_all(31'($urandom_range(0, 3)), 31'($urandom_range(0, 1 << 22)),
                 31'($urandom_range(1 << 20, 1 << 24)), 31'($urandom_range(1 << 12, 1 << 19)),
                 31'($urandom_range(0, 1 << 23)), 31'($urandom_range(0, 1 << 14)));
         random_phase(50, 3, 40);
      end

      drain();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && vertex_q.size() == 0) begin
         $display("tb_gravity_ray_march_step: PASS");
      end else begin
         $display("tb_gravity_ray_march_step: FAIL");
      end
      $finish;
   end

endmodule
